// ===== rtl/core/motor_speed_p_controller_pwm_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef MOTOR_SPEED_P_CONTROLLER_PWM_MACROS_SVH
`define MOTOR_SPEED_P_CONTROLLER_PWM_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define MSPC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define MSPC_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mspc_pkg.sv =====
package mspc_pkg;

  localparam int SPEED_W    = 16;
  localparam int RPM_W      = 10;
  localparam int GAIN_W     = 6;
  localparam int DUTY_W     = 7;
  localparam int PINS_W     = 3;
  localparam int SETPT_W    = 12;
  localparam int CFG_DATA_W = RPM_W;
  localparam int CFG_ADDR_W = 1;

  localparam int PWM_PERIOD = 100;
  localparam int HIST_LEN   = 3;
  localparam int DUTY_MAX   = 100;

  localparam int PHASE_W = $clog2(PWM_PERIOD);
  localparam int CMP_W   = $clog2(DUTY_MAX * PWM_PERIOD + 1);

  // Reciprocal multiply for the history average: exact for sums below 2^SUM_W
  localparam int SUM_W   = SPEED_W + $clog2(HIST_LEN);
  localparam int DIV_K   = SUM_W + $clog2(HIST_LEN);
  localparam int DIV_M_W = SUM_W + 1;
  localparam int DIV_P_W = SUM_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_M =
    DIV_M_W'(((64'd1 << DIV_K) + 64'(HIST_LEN) - 64'd1) / 64'(HIST_LEN));

  localparam logic [RPM_W-1:0]  RPM_RESET  = RPM_W'(50);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(5);
  localparam logic [PINS_W-1:0] PINS_ALL   = '1;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_WINDOW = 2'd1,
    OP_PWM    = 2'd2
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_RPM_PER_PULSE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN     = 1'd1;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_now;
    logic [SPEED_W-1:0] avg_speed;
    logic               pwm_level;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic [SETPT_W-1:0] setpoint(input logic [PINS_W-1:0] idx);
    logic [SETPT_W-1:0] sp;
    unique case (idx)
      3'd0:    sp = SETPT_W'(0);
      3'd1:    sp = SETPT_W'(240);
      3'd2:    sp = SETPT_W'(720);
      3'd3:    sp = SETPT_W'(1200);
      3'd4:    sp = SETPT_W'(1440);
      3'd5:    sp = SETPT_W'(1680);
      3'd6:    sp = SETPT_W'(1920);
      default: sp = SETPT_W'(2400);
    endcase
    return sp;
  endfunction

endpackage

// ===== rtl/core/motor_speed_p_controller_pwm.sv =====
// Proportional motor speed controller with PWM drive. Each input transaction
// carries an event kind on s_tuser (encoder falling edge, measurement window
// tick, PWM time tick) and the raw active-low setpoint switches on s_tdata.
// Encoder edges are counted; a window tick makes the average speed the floor
// of the mean of the previous three window speeds, then shifts in the new
// window speed (edge count times rpm_per_pulse, saturated to 16 bits) and
// clears the count. A PWM tick at phase zero latches a duty of
// (setpoint - average) * prop_gain, clamped to 0..100 percent, and the drive
// level is high while the phase is below the duty over a 100-tick period.
// Every input transaction yields exactly one output transaction with the
// drive level, average speed and latched duty after that event. The block
// takes one transaction per clock while s_tready is high: state updates and
// the result are formed in the cycle of acceptance and the result is
// registered. A one-entry skid buffer behind the result register keeps s_tready
// high while a single result waits on m_tready; s_tready drops only when
// both the result register and the skid entry are full. Configuration
// writes (cfg_we, cfg_addr, cfg_data) take effect at once; write them only
// while no transaction is in flight. Index 0 is rpm_per_pulse (reset 50),
// index 1 is prop_gain (reset 5, low 6 bits of cfg_data).
module motor_speed_p_controller_pwm
  import mspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [2:0] switch_pins, [7:3] zero
  input  logic [1:0]            s_tuser,   // [1:0] op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // [0] pwm_level, [16:1] avg_speed, [23:17] duty_now
);

  cfg_wr_t cfg;
  result_t res_new;
  result_t out_res;
  result_t skid_res;
  logic    out_valid;
  logic    skid_valid;
  logic    take;

  assign cfg      = '{we: cfg_we, addr: cfg_addr, data: cfg_data};
  assign s_tready = !skid_valid;
  assign take     = s_tvalid && s_tready;

  mspc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_take   (take),
    .op          (s_tuser),
    .switch_pins (s_tdata[PINS_W-1:0]),
    .res         (res_new)
  );

  // Output register with one skid entry. When the output drains, refill it
  // from the skid entry first, otherwise from the new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      // hold the stalled result; park the new one
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (take) begin
        out_res <= res_new;
      end
    end else if (take) begin
      skid_res <= res_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.duty_now, out_res.avg_speed, out_res.pwm_level};

endmodule

// ===== rtl/core/mspc_core.sv =====
module mspc_core
  import mspc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_wr_t           cfg,
  input  logic              item_take,
  input  logic [1:0]        op,
  input  logic [PINS_W-1:0] switch_pins,
  output result_t           res
);

  localparam logic [CMP_W-1:0] DUTY_SCALE   = CMP_W'(DUTY_MAX);
  localparam logic [CMP_W-1:0] PERIOD_SCALE = CMP_W'(PWM_PERIOD);
  localparam int ERR_W  = SPEED_W + 1;
  localparam int PROD_W = ERR_W + GAIN_W + 1;

  logic [RPM_W-1:0]   rpm_per_pulse;
  logic [GAIN_W-1:0]  prop_gain;
  logic [SPEED_W-1:0] edge_count, edge_count_next;
  logic [SPEED_W-1:0] hist [HIST_LEN];
  logic [SPEED_W-1:0] speed_average, speed_average_next;
  logic [PHASE_W-1:0] pwm_phase, pwm_phase_next;
  logic [DUTY_W-1:0]  duty_latch, duty_latch_next;
  logic               drive, drive_next;
  logic               window_step;

  logic [SUM_W-1:0]           hist_sum;
  logic [DIV_P_W-1:0]         quot_prod;
  logic [SPEED_W+RPM_W-1:0]   speed_prod;
  logic [SPEED_W-1:0]         window_speed;
  logic signed [ERR_W-1:0]    speed_err;
  logic signed [PROD_W-1:0]   duty_raw;
  logic [DUTY_W-1:0]          duty_clamped;
  logic [CMP_W-1:0]           phase_scaled, duty_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_per_pulse <= RPM_RESET;
      prop_gain     <= GAIN_RESET;
    end else if (cfg.we) begin
      unique case (cfg.addr)
        CFG_RPM_PER_PULSE: rpm_per_pulse <= cfg.data;
        CFG_PROP_GAIN:     prop_gain     <= cfg.data[GAIN_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    hist_sum = '0;
    for (int i = 0; i < HIST_LEN; i++) begin
      hist_sum = hist_sum + SUM_W'(hist[i]);
    end
    quot_prod    = DIV_P_W'(hist_sum) * DIV_P_W'(DIV_M);
    speed_prod   = (SPEED_W+RPM_W)'(edge_count) * (SPEED_W+RPM_W)'(rpm_per_pulse);
    window_speed = (|speed_prod[SPEED_W+RPM_W-1:SPEED_W]) ? '1 : speed_prod[SPEED_W-1:0];

    speed_err = $signed(ERR_W'(setpoint(PINS_ALL - switch_pins)))
              - $signed({1'b0, speed_average});
    duty_raw  = PROD_W'(speed_err) * $signed({1'b0, prop_gain});
    if (duty_raw <= 0) begin
      duty_clamped = '0;
    end else if (duty_raw >= PROD_W'(DUTY_MAX)) begin
      duty_clamped = DUTY_W'(DUTY_MAX);
    end else begin
      duty_clamped = duty_raw[DUTY_W-1:0];
    end
  end

  always_comb begin
    edge_count_next    = edge_count;
    speed_average_next = speed_average;
    pwm_phase_next     = pwm_phase;
    duty_latch_next    = duty_latch;
    drive_next         = drive;
    window_step        = 1'b0;
    phase_scaled       = CMP_W'(pwm_phase) * DUTY_SCALE;
    duty_scaled        = '0;
    if (item_take) begin
      unique case (op)
        OP_EDGE: begin
          edge_count_next = edge_count + SPEED_W'(1);
        end
        OP_WINDOW: begin
          speed_average_next = quot_prod[DIV_K +: SPEED_W];
          edge_count_next    = '0;
          window_step        = 1'b1;
        end
        OP_PWM: begin
          // latch a fresh duty at the start of each period
          if (pwm_phase == '0) begin
            duty_latch_next = duty_clamped;
          end
          duty_scaled    = CMP_W'(duty_latch_next) * PERIOD_SCALE;
          drive_next     = phase_scaled < duty_scaled;
          pwm_phase_next = (pwm_phase == PHASE_W'(PWM_PERIOD - 1)) ? '0
                         : pwm_phase + PHASE_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      speed_average <= '0;
      pwm_phase     <= '0;
      duty_latch    <= '0;
      drive         <= 1'b0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= '0;
      end
    end else begin
      edge_count    <= edge_count_next;
      speed_average <= speed_average_next;
      pwm_phase     <= pwm_phase_next;
      duty_latch    <= duty_latch_next;
      drive         <= drive_next;
      if (window_step) begin
        for (int i = 0; i < HIST_LEN - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HIST_LEN-1] <= window_speed;
      end
    end
  end

  assign res.pwm_level = drive_next;
  assign res.avg_speed = speed_average_next;
  assign res.duty_now  = duty_latch_next;

endmodule

// ===== rtl/core/mspc_checker.sv =====
`include "motor_speed_p_controller_pwm_macros.svh"

module mspc_checker
  import mspc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Duty field stays within 0..100 percent.
  `MSPC_ASSERT_RUN(a_duty_range, m_tvalid |-> (m_tdata[23:17] <= DUTY_W'(DUTY_MAX)), "duty above 100")
  // Drive high requires a nonzero latched duty.
  `MSPC_ASSERT_RUN(a_drive_duty, (m_tvalid && m_tdata[0]) |-> (m_tdata[23:17] != '0), "drive high at zero duty")
  // Stalled result holds its payload.
  `MSPC_ASSERT_RUN(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
  // Reset empties the output.
  `MSPC_ASSERT_ALL(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")
  // Input side never backs up while the output is empty.
  `MSPC_ASSERT_RUN(a_ready_idle, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

bind motor_speed_p_controller_pwm mspc_checker u_mspc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
